>>> hdl/bcsc_pkg.sv
package bcsc_pkg;

  localparam int unsigned CoordW   = 10;
  localparam int unsigned MinSpanW = 10;
  localparam int unsigned TolW     = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned DistW    = 2 * CoordW + 1;
  localparam int unsigned MulBW    = 16;
  localparam int unsigned ProdW    = DistW + MulBW;
  localparam int unsigned SpanW    = (CoordW > MinSpanW) ? CoordW : MinSpanW;
  localparam int unsigned StepW    = 5;

  localparam logic [CfgIdxW-1:0] CfgMinSpan   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgTolerance = CfgIdxW'(1);

  localparam logic [MinSpanW-1:0] MinSpanReset   = MinSpanW'(15);
  localparam logic [TolW-1:0]     ToleranceReset = TolW'(20);
  localparam logic [TolW-1:0]     Hundred        = TolW'(100);
  localparam logic [MulBW-1:0]    Scale          = MulBW'(10000);

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } point_t;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic              last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [CoordW-1:0] left_x;
    logic [CoordW-1:0] left_y;
    logic [CoordW-1:0] top_x;
    logic [CoordW-1:0] top_y;
    logic [CoordW-1:0] bottom_x;
    logic [CoordW-1:0] bottom_y;
    logic [CoordW-1:0] right_x;
    logic [CoordW-1:0] right_y;
    logic              is_regular;
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
  } result_t;

  function automatic logic [CoordW-1:0] absdiff(input logic [CoordW-1:0] a,
                                                input logic [CoordW-1:0] b);
    absdiff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

>>> hdl/blob_extreme_corner_square_check.sv
// Tracks the leftmost, topmost, bottommost and rightmost points of one blob whose pixels
// arrive one request each, and on the last pixel reports the four corners, the truncated
// center and a regularity flag (span checks, then the diagonal pair and the side pair of
// exact squared lengths compared within the tolerance in whole percent). A pixel that is
// not the last one is taken while the block is idle. After a last pixel no pixel is taken
// until one shared 21x16 multiplier has been stepped through 16 products (eight squared
// coordinate differences, the two squared tolerance factors and six scaled lengths) by an
// 18-step sequencer. The result sits in an output register, so pixels of the next blob
// are taken while it waits; a further last pixel waits at the end of its sequence until
// the previous result has gone.
module blob_extreme_corner_square_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bcsc_pkg::pixel_t               in_pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bcsc_pkg::result_t              out_result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bcsc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bcsc_pkg::CfgDataW-1:0]  cfg_data_i
);

  typedef enum logic {
    StIdle,
    StCalc
  } state_e;

  localparam logic [bcsc_pkg::StepW-1:0] OpD1X     = 5'd0;
  localparam logic [bcsc_pkg::StepW-1:0] OpD1Y     = 5'd1;
  localparam logic [bcsc_pkg::StepW-1:0] OpD2X     = 5'd2;
  localparam logic [bcsc_pkg::StepW-1:0] OpD2Y     = 5'd3;
  localparam logic [bcsc_pkg::StepW-1:0] OpD3X     = 5'd4;
  localparam logic [bcsc_pkg::StepW-1:0] OpD3Y     = 5'd5;
  localparam logic [bcsc_pkg::StepW-1:0] OpD4X     = 5'd6;
  localparam logic [bcsc_pkg::StepW-1:0] OpD4Y     = 5'd7;
  localparam logic [bcsc_pkg::StepW-1:0] OpHiSq    = 5'd8;
  localparam logic [bcsc_pkg::StepW-1:0] OpLoSq    = 5'd9;
  localparam logic [bcsc_pkg::StepW-1:0] OpScaleD1 = 5'd10;
  localparam logic [bcsc_pkg::StepW-1:0] OpHiD2    = 5'd11;
  localparam logic [bcsc_pkg::StepW-1:0] OpLoD2    = 5'd12;
  localparam logic [bcsc_pkg::StepW-1:0] OpScaleD3 = 5'd13;
  localparam logic [bcsc_pkg::StepW-1:0] OpHiD4    = 5'd14;
  localparam logic [bcsc_pkg::StepW-1:0] OpLoD4    = 5'd15;
  localparam logic [bcsc_pkg::StepW-1:0] StepFinal = 5'd17;
  localparam logic [bcsc_pkg::StepW-1:0] OpNone    = 5'd31;

  state_e                                state_q;
  logic [bcsc_pkg::StepW-1:0]            step_q;
  logic [bcsc_pkg::StepW-1:0]            prod_op_q;
  logic                                  started_q;
  logic [bcsc_pkg::MinSpanW-1:0]         min_span_q;
  logic [bcsc_pkg::TolW-1:0]             tol_q;
  bcsc_pkg::point_t                      left_q, top_q, bottom_q, right_q;
  bcsc_pkg::point_t                      left_d, top_d, bottom_d, right_d;
  logic [bcsc_pkg::ProdW-1:0]            prod_q, prod_d;
  logic [bcsc_pkg::DistW-1:0]            acc_q, d1_q, d2_q, d3_q, d4_q;
  logic [bcsc_pkg::MulBW-1:0]            hi2_q, lo2_q;
  logic [bcsc_pkg::ProdW-1:0]            e_q;
  logic                                  fail1_q, fail2_q;
  logic                                  out_valid_q;
  bcsc_pkg::result_t                     result_q, result_d;

  logic                                  in_accept;
  logic                                  out_free;
  logic [bcsc_pkg::CoordW-1:0]           sel_p, sel_q, diff;
  logic [bcsc_pkg::TolW:0]               hi, lo;
  logic                                  tol_lt100;
  logic [bcsc_pkg::DistW-1:0]            op_a;
  logic [bcsc_pkg::MulBW-1:0]            op_b;
  logic [bcsc_pkg::DistW-1:0]            d_sum;
  logic [bcsc_pkg::CoordW-1:0]           span_x, span_y;
  logic                                  span_ok, ratio_ok;
  logic [bcsc_pkg::CoordW:0]             sum_x, sum_y;
  bcsc_pkg::point_t                      pix;

  assign in_stall_o   = (state_q != StIdle);
  assign in_accept    = in_valid_i && (state_q == StIdle);
  assign out_valid_o  = out_valid_q;
  assign out_result_o = result_q;
  assign cfg_ready_o  = 1'b1;
  assign out_free     = !out_valid_q || !out_stall_i;

  assign pix.x = in_pixel_i.pixel_x;
  assign pix.y = in_pixel_i.pixel_y;

  always_comb begin
    left_d   = left_q;
    top_d    = top_q;
    bottom_d = bottom_q;
    right_d  = right_q;
    if (!started_q) begin
      left_d   = pix;
      top_d    = pix;
      bottom_d = pix;
      right_d  = pix;
    end else begin
      if (pix.x < left_q.x || (pix.x == left_q.x && pix.y < left_q.y)) begin
        left_d = pix;
      end
      if (pix.y < top_q.y || (pix.y == top_q.y && pix.x < top_q.x)) begin
        top_d = pix;
      end
      if (pix.y > bottom_q.y || (pix.y == bottom_q.y && pix.x > bottom_q.x)) begin
        bottom_d = pix;
      end
      if (pix.x > right_q.x || (pix.x == right_q.x && pix.y > right_q.y)) begin
        right_d = pix;
      end
    end
  end

  assign tol_lt100 = (tol_q < bcsc_pkg::Hundred);
  assign hi        = {1'b0, tol_q} + {1'b0, bcsc_pkg::Hundred};
  assign lo        = {1'b0, bcsc_pkg::Hundred} - {1'b0, tol_q};

  always_comb begin
    sel_p = '0;
    sel_q = '0;
    case (step_q)
      OpD1X: begin
        sel_p = right_q.x;
        sel_q = left_q.x;
      end
      OpD1Y: begin
        sel_p = right_q.y;
        sel_q = left_q.y;
      end
      OpD2X: begin
        sel_p = bottom_q.x;
        sel_q = top_q.x;
      end
      OpD2Y: begin
        sel_p = bottom_q.y;
        sel_q = top_q.y;
      end
      OpD3X: begin
        sel_p = right_q.x;
        sel_q = bottom_q.x;
      end
      OpD3Y: begin
        sel_p = right_q.y;
        sel_q = bottom_q.y;
      end
      OpD4X: begin
        sel_p = left_q.x;
        sel_q = top_q.x;
      end
      OpD4Y: begin
        sel_p = left_q.y;
        sel_q = top_q.y;
      end
      default: begin
        sel_p = '0;
        sel_q = '0;
      end
    endcase
  end

  assign diff = bcsc_pkg::absdiff(sel_p, sel_q);

  always_comb begin
    op_a = bcsc_pkg::DistW'(diff);
    op_b = bcsc_pkg::MulBW'(diff);
    case (step_q)
      OpHiSq: begin
        op_a = bcsc_pkg::DistW'(hi);
        op_b = bcsc_pkg::MulBW'(hi);
      end
      OpLoSq: begin
        op_a = bcsc_pkg::DistW'(lo);
        op_b = bcsc_pkg::MulBW'(lo);
      end
      OpScaleD1: begin
        op_a = d1_q;
        op_b = bcsc_pkg::Scale;
      end
      OpHiD2: begin
        op_a = d2_q;
        op_b = hi2_q;
      end
      OpLoD2: begin
        op_a = d2_q;
        op_b = lo2_q;
      end
      OpScaleD3: begin
        op_a = d3_q;
        op_b = bcsc_pkg::Scale;
      end
      OpHiD4: begin
        op_a = d4_q;
        op_b = hi2_q;
      end
      OpLoD4: begin
        op_a = d4_q;
        op_b = lo2_q;
      end
      default: begin
        op_a = bcsc_pkg::DistW'(diff);
        op_b = bcsc_pkg::MulBW'(diff);
      end
    endcase
  end

  assign prod_d = bcsc_pkg::ProdW'(op_a) * bcsc_pkg::ProdW'(op_b);
  assign d_sum  = acc_q + bcsc_pkg::DistW'(prod_q);

  assign span_x  = right_q.x - left_q.x;
  assign span_y  = bottom_q.y - top_q.y;
  assign span_ok = (right_q.x >= left_q.x)
                && (bcsc_pkg::SpanW'(span_x) >= bcsc_pkg::SpanW'(min_span_q))
                && (bottom_q.y >= top_q.y)
                && (bcsc_pkg::SpanW'(span_y) >= bcsc_pkg::SpanW'(min_span_q));
  assign ratio_ok = (d2_q != '0) && !fail1_q
                 && (((d4_q != '0) && !fail2_q) || ((d3_q == '0) && (d4_q == '0)));
  assign sum_x   = {1'b0, left_q.x} + {1'b0, right_q.x};
  assign sum_y   = {1'b0, top_q.y} + {1'b0, bottom_q.y};

  always_comb begin
    result_d.left_x     = left_q.x;
    result_d.left_y     = left_q.y;
    result_d.top_x      = top_q.x;
    result_d.top_y      = top_q.y;
    result_d.bottom_x   = bottom_q.x;
    result_d.bottom_y   = bottom_q.y;
    result_d.right_x    = right_q.x;
    result_d.right_y    = right_q.y;
    result_d.is_regular = span_ok && ratio_ok;
    result_d.center_x   = sum_x[bcsc_pkg::CoordW:1];
    result_d.center_y   = sum_y[bcsc_pkg::CoordW:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      prod_op_q   <= OpNone;
      started_q   <= 1'b0;
      min_span_q  <= bcsc_pkg::MinSpanReset;
      tol_q       <= bcsc_pkg::ToleranceReset;
      out_valid_q <= 1'b0;
      fail1_q     <= 1'b0;
      fail2_q     <= 1'b0;
      left_q      <= '1;
      top_q       <= '1;
      bottom_q    <= '0;
      right_q     <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      d1_q        <= '0;
      d2_q        <= '0;
      d3_q        <= '0;
      d4_q        <= '0;
      hi2_q       <= '0;
      lo2_q       <= '0;
      e_q         <= '0;
      result_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          bcsc_pkg::CfgMinSpan:   min_span_q <= cfg_data_i[bcsc_pkg::MinSpanW-1:0];
          bcsc_pkg::CfgTolerance: tol_q      <= cfg_data_i[bcsc_pkg::TolW-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && (state_q != StCalc || step_q != StepFinal)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_accept) begin
            left_q    <= left_d;
            top_q     <= top_d;
            bottom_q  <= bottom_d;
            right_q   <= right_d;
            started_q <= 1'b1;
            if (in_pixel_i.last_pixel) begin
              state_q   <= StCalc;
              step_q    <= '0;
              prod_op_q <= OpNone;
              fail1_q   <= 1'b0;
              fail2_q   <= 1'b0;
            end
          end
        end
        StCalc: begin
          prod_q    <= prod_d;
          prod_op_q <= step_q;
          case (prod_op_q)
            OpD1X, OpD2X, OpD3X, OpD4X: acc_q <= bcsc_pkg::DistW'(prod_q);
            OpD1Y:     d1_q  <= d_sum;
            OpD2Y:     d2_q  <= d_sum;
            OpD3Y:     d3_q  <= d_sum;
            OpD4Y:     d4_q  <= d_sum;
            OpHiSq:    hi2_q <= bcsc_pkg::MulBW'(prod_q);
            OpLoSq:    lo2_q <= bcsc_pkg::MulBW'(prod_q);
            OpScaleD1: e_q   <= prod_q;
            OpScaleD3: e_q   <= prod_q;
            OpHiD2: begin
              if (prod_q < e_q) fail1_q <= 1'b1;
            end
            OpLoD2: begin
              if (tol_lt100 && prod_q > e_q) fail1_q <= 1'b1;
            end
            OpHiD4: begin
              if (prod_q < e_q) fail2_q <= 1'b1;
            end
            OpLoD4: begin
              if (tol_lt100 && prod_q > e_q) fail2_q <= 1'b1;
            end
            default: ;
          endcase
          if (step_q == StepFinal) begin
            if (out_free) begin
              result_q    <= result_d;
              out_valid_q <= 1'b1;
              started_q   <= 1'b0;
              state_q     <= StIdle;
            end
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
